/* design/me_pkg.sv */
// ----------------------------------------------------------------------------
// me_pkg
// Shared constants and controller/datapath types for modular exponentiation.
// ----------------------------------------------------------------------------
package me_pkg;

  // fixed width of the base, exponent, modulus and result fields
  localparam int unsigned FIELD_W = 63;

  // default datapath width
  localparam int unsigned OPERAND_BITS_DEF = 63;

  // configuration port geometry: registers on 8-byte strides
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;

  // register index of the modulus (paddr bits above the byte offset)
  localparam logic [PADDR_W-4:0] REG_MODULUS = '0;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_start;
    logic mul_step;
    logic finish;
  } me_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic m_le1;
    logic e_zero;
    logic cnt_zero;
  } me_sts_t;

endpackage

/* design/me_req_if.sv */
// ----------------------------------------------------------------------------
// me_req_if
// Request channel: base and exponent with valid/ready handshake.
// ----------------------------------------------------------------------------
interface me_req_if import me_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);

endinterface

/* design/me_rsp_if.sv */
// ----------------------------------------------------------------------------
// me_rsp_if
// Response channel: power_mod result with valid/ready handshake.
// ----------------------------------------------------------------------------
interface me_rsp_if import me_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);

endinterface

/* design/me_dp.sv */
// ----------------------------------------------------------------------------
// me_dp
// Datapath: base reduction, two parallel shift-add modular multipliers
// (acc * p and p * p), exponent shifter and result register.
// ----------------------------------------------------------------------------
module me_dp import me_pkg::*; #(
  parameter int unsigned W = OPERAND_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  me_cmd_t            cmd_i,
  input  logic [W-1:0]       modulus_i,
  input  logic [FIELD_W-1:0] base_i,
  input  logic [FIELD_W-1:0] exponent_i,
  output me_sts_t            sts_o,
  output logic [FIELD_W-1:0] power_mod_o
);

  localparam int unsigned NW = W + 2;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  x_q, p_q, acc_q, e_q, b_q, ra_q, rp_q, res_q;
  logic [CW-1:0] cnt_q;

  logic [NW-1:0] m1, m2;
  logic [NW-1:0] ra_sum, rp_sum, rp_add;
  logic [W-1:0]  rp_base;
  logic [W-1:0]  ra_nx, rp_nx;

  // reduce a sum below 3m into [0, m) with two parallel compares
  function automatic logic [W-1:0] red3(input logic [NW-1:0] s,
                                        input logic [NW-1:0] mm1,
                                        input logic [NW-1:0] mm2);
    logic [NW-1:0] r;
    r = s;
    if (s >= mm2) begin
      r = s - mm2;
    end else if (s >= mm1) begin
      r = s - mm1;
    end
    return r[W-1:0];
  endfunction

  // modulus and its double
  assign m1 = NW'(modulus_i);
  assign m2 = m1 << 1;

  // acc * p unit: one multiplier bit per cycle, msb first
  assign ra_sum = (NW'(ra_q) << 1) + (b_q[W-1] ? NW'(acc_q) : '0);
  assign ra_nx  = red3(ra_sum, m1, m2);

  // p * p unit, also used for the initial base reduction
  assign rp_base = cmd_i.red_step ? p_q : rp_q;
  assign rp_add  = cmd_i.red_step ? NW'(x_q[W-1]) : (b_q[W-1] ? NW'(p_q) : '0);
  assign rp_sum  = (NW'(rp_base) << 1) + rp_add;
  assign rp_nx   = red3(rp_sum, m1, m2);

  // operand and partial product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= W'(base_i);
      e_q   <= W'(exponent_i);
      p_q   <= '0;
      acc_q <= W'(1);
    end
    if (cmd_i.red_step) begin
      p_q <= rp_nx;
      x_q <= x_q << 1;
    end
    if (cmd_i.mul_start) begin
      ra_q <= '0;
      rp_q <= '0;
      b_q  <= p_q;
    end
    if (cmd_i.mul_step) begin
      if (sts_o.cnt_zero) begin
        if (e_q[0]) begin
          acc_q <= ra_nx;
        end
        p_q <= rp_nx;
        e_q <= e_q >> 1;
      end else begin
        ra_q <= ra_nx;
        rp_q <= rp_nx;
        b_q  <= b_q << 1;
      end
    end
    if (cmd_i.finish) begin
      res_q <= sts_o.m_le1 ? '0 : acc_q;
    end
  end

  // bit counter for reduction and multiply passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.mul_start) begin
      cnt_q <= CW'(W - 1);
    end else if ((cmd_i.red_step || cmd_i.mul_step) && !sts_o.cnt_zero) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // status back to the controller
  assign sts_o.m_le1    = (modulus_i <= W'(1));
  assign sts_o.e_zero   = (e_q == '0);
  assign sts_o.cnt_zero = (cnt_q == '0);

  assign power_mod_o = FIELD_W'(res_q);

endmodule

/* design/me_ctrl.sv */
// ----------------------------------------------------------------------------
// me_ctrl
// Controller: sequences base reduction, square-and-multiply rounds and
// result hand-off; owns the request ready and response valid.
// ----------------------------------------------------------------------------
module me_ctrl import me_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  me_sts_t sts_i,
  output me_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_ROUND,
    S_MUL,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   vld_q;

  // command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.load      = req_valid_i;
      S_REDUCE: cmd_o.red_step  = 1'b1;
      S_ROUND:  cmd_o.mul_start = !sts_i.e_zero;
      S_MUL:    cmd_o.mul_step  = 1'b1;
      S_FINISH: cmd_o.finish    = !vld_q || rsp_ready_i;
      default:  cmd_o = '0;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = vld_q;

  // state and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= (vld_q && !rsp_ready_i) || cmd_o.finish;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= sts_i.m_le1 ? S_FINISH : S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (sts_i.cnt_zero) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          state_q <= sts_i.e_zero ? S_FINISH : S_MUL;
        end
        S_MUL: begin
          if (sts_i.cnt_zero) begin
            state_q <= S_ROUND;
          end
        end
        S_FINISH: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left binary exponentiation modulo a configured modulus.
//
//   channel  dir  handshake            word
//   req_i    in   valid/ready          base, exponent
//   rsp_o    out  valid/ready          power_mod
//   apb      in   psel/penable/pwrite  modulus at address 0
//
// Each item runs a reduction of the base, then one square-and-multiply round
// per exponent bit up to its highest set bit; a modulus of 0 or 1 goes
// straight to the result. The work is done by the shift-add multipliers,
// which retire one multiplier bit per cycle, with acc * p and p * p in
// parallel. Reset sets the modulus to 1 and idles the controller. A stalled
// result sits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module modular_exponentiation import me_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  me_req_if.sink             req_i,
  me_rsp_if.source           rsp_o
);

  logic [OPERAND_BITS-1:0] modulus_q;
  logic                    reg_hit;
  me_cmd_t                 cmd;
  me_sts_t                 sts;

  // register decode
  assign reg_hit = (paddr[PADDR_W-1:3] == REG_MODULUS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(modulus_q) : '0;

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= OPERAND_BITS'(1);
    end else if (psel && penable && pwrite && reg_hit) begin
      modulus_q <= OPERAND_BITS'(pwdata);
    end
  end

  // sequencing
  me_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic
  me_dp #(
    .W (OPERAND_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .modulus_i   (modulus_q),
    .base_i      (req_i.base),
    .exponent_i  (req_i.exponent),
    .sts_o       (sts),
    .power_mod_o (rsp_o.power_mod)
  );

endmodule

/* tb/power_mod_checker.sv */
// ----------------------------------------------------------------------------
// power_mod_checker
// Watches the config port and both word channels of the modular
// exponentiation block, predicts base^exponent mod modulus for every accepted
// request word and compares each accepted response word in order.
// ----------------------------------------------------------------------------
module power_mod_checker import me_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  me_req_if                  req_i,
  me_rsp_if                  rsp_i,
  output int unsigned        fail_count_o,
  output int unsigned        outstanding_o
);

  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [2*FIELD_W-1:0] wide_t;

  // operands and modulus are cut to the datapath width
  localparam int unsigned OPERAND_BITS = OPERAND_BITS_DEF;
  localparam field_t OPERAND_MASK = (OPERAND_BITS >= FIELD_W) ? '1 :
                                    field_t'((64'd1 << OPERAND_BITS) - 64'd1);

  field_t      modulus_q;
  field_t      power_mod_q[$];
  int unsigned fail_count;

  assign fail_count_o = fail_count;

  // a * b mod m through a double-width product
  function automatic field_t mulmod(input field_t a, input field_t b, input field_t m);
    wide_t prod;
    prod = wide_t'(a) * wide_t'(b);
    return field_t'(prod % wide_t'(m));
  endfunction

  // right-to-left square and multiply over every exponent bit
  function automatic field_t predict_power_mod(input field_t base, input field_t exponent,
                                               input field_t m);
    field_t p;
    field_t acc;
    if (m <= field_t'(1)) return '0;
    p   = (base & OPERAND_MASK) % m;
    acc = field_t'(1);
    for (int i = 0; i < FIELD_W; i++) begin
      if (exponent[i] && OPERAND_MASK[i]) acc = mulmod(acc, p, m);
      p = mulmod(p, p, m);
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input field_t got, input field_t want);
    $display("[%0t] power_mod_checker: %s: got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // register shadow, prediction and in-order compare
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q = field_t'(1);
      power_mod_q.delete();
      outstanding_o <= 0;
    end else begin
      // config access; only index 0 maps to the modulus
      if (psel && penable && pready && paddr[PADDR_W-1:3] == REG_MODULUS) begin
        if (pwrite) begin
          modulus_q = pwdata[FIELD_W-1:0] & OPERAND_MASK;
        end else if (prdata[FIELD_W-1:0] !== modulus_q) begin
          report_mismatch("modulus readback", prdata[FIELD_W-1:0], modulus_q);
        end
      end
      // request word accepted
      if (req_i.valid && req_i.ready) begin
        power_mod_q = {power_mod_q,
                       predict_power_mod(req_i.base, req_i.exponent, modulus_q)};
      end
      // response word accepted
      if (rsp_i.valid && rsp_i.ready) begin
        if (power_mod_q.size() == 0) begin
          report_mismatch("response word with none pending", rsp_i.power_mod, '0);
        end else if (rsp_i.power_mod !== power_mod_q[0]) begin
          report_mismatch("power_mod", rsp_i.power_mod, power_mod_q.pop_front());
        end else begin
          void'(power_mod_q.pop_front());
        end
      end
      outstanding_o <= power_mod_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the modular exponentiation block through its config port and
// request channel with directed corner words and random sessions at several
// moduli, stalls both sides at random, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;
  import me_pkg::*;

  typedef logic [FIELD_W-1:0] field_t;

  localparam int unsigned LONG_HOLD        = 10000;
  localparam int unsigned RANDOM_PER_PHASE = 31;
  localparam int unsigned END_CYCLES       = 100;

  localparam logic [PADDR_W-1:0] ADDR_MODULUS  = PADDR_W'({REG_MODULUS, 3'b000});
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = ADDR_MODULUS + PADDR_W'(8);

  localparam field_t FIELD_MAX = '1;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int unsigned        fail_count;
  int unsigned        outstanding;
  bit                 long_hold_req;

  me_req_if req_ch ();
  me_rsp_if rsp_ch ();

  modular_exponentiation DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  power_mod_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic field_t rand_field();
    return field_t'({$urandom, $urandom});
  endfunction

  // apb write: setup then access
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // apb read, value checked by the checker
  task automatic apb_read(input logic [PADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // offer one request word after a random gap, return at its acceptance
  task automatic send_word(input field_t base, input field_t exponent);
    int unsigned gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.base     <= base;
    req_ch.exponent <= exponent;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // one session at a given modulus with random words
  task automatic run_random_phase(input field_t modulus, input bit squeeze);
    field_t      base;
    field_t      exponent;
    int unsigned pick;
    int unsigned len;
    apb_write(ADDR_MODULUS, PDATA_W'(modulus));
    apb_read(ADDR_MODULUS);
    if (squeeze) long_hold_req = 1'b1;
    repeat (RANDOM_PER_PHASE) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: base = '0;
        1: base = modulus - field_t'(1);
        2: base = modulus;
        3: base = FIELD_MAX;
        default: base = rand_field();
      endcase
      // mostly short exponents keep the run fast; a few use every bit
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        exponent = rand_field();
      end else if (pick == 1) begin
        exponent = '0;
      end else begin
        len      = $urandom_range(1, 16);
        exponent = rand_field() & field_t'((64'd1 << len) - 64'd1);
      end
      send_word(base, exponent);
    end
    drain_results();
  endtask

  // response side: random stalls, free-running stretches, one long hold
  initial begin
    int unsigned pick;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          rsp_ch.ready <= 1'b0;
          repeat (idle_len()) @(posedge clk);
        end else if (pick < 30) begin
          rsp_ch.ready <= 1'b1;
          repeat ($urandom_range(100, 400)) @(posedge clk);
        end else begin
          rsp_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    long_hold_req    = 1'b0;
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.base     <= '0;
    req_ch.exponent <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // modulus left at its reset value of one: always zero
    apb_read(ADDR_MODULUS);
    send_word('0, '0);
    send_word(FIELD_MAX, FIELD_MAX);
    send_word(field_t'(5), field_t'(3));
    drain_results();

    // largest modulus; bit 63 of the write data is dropped
    apb_write(ADDR_MODULUS, '1);
    apb_read(ADDR_MODULUS);
    send_word('0, '0);
    send_word('0, field_t'(7));
    send_word(FIELD_MAX, field_t'(1));
    send_word(FIELD_MAX - field_t'(1), field_t'(2));
    send_word(FIELD_MAX - field_t'(1), field_t'(3));
    send_word(field_t'(12345), '0);
    send_word(field_t'(2), field_t'(62));
    send_word(field_t'(3), FIELD_MAX);
    drain_results();

    // modulus zero after masking
    apb_write(ADDR_MODULUS, {1'b1, {(PDATA_W-1){1'b0}}});
    apb_read(ADDR_MODULUS);
    send_word(field_t'(7), field_t'(3));
    send_word(FIELD_MAX, FIELD_MAX);
    drain_results();

    // prime modulus; a write past the register list must leave it alone
    apb_write(ADDR_MODULUS, PDATA_W'(1000003));
    apb_write(ADDR_UNMAPPED, PDATA_W'(5));
    apb_read(ADDR_MODULUS);
    send_word(field_t'(2), field_t'(10));
    send_word(field_t'(1000008), field_t'(2));
    send_word(FIELD_MAX, field_t'(20));
    drain_results();

    // smallest modulus that gives nonzero results
    apb_write(ADDR_MODULUS, PDATA_W'(2));
    send_word(field_t'(3), field_t'(5));
    drain_results();

    // random sessions; the first one also backs up the block
    run_random_phase(rand_field() | {1'b1, {(FIELD_W-1){1'b0}}}, 1'b1);
    run_random_phase(field_t'($urandom_range(2, 1000)), 1'b0);
    run_random_phase(field_t'($urandom) | field_t'(1), 1'b0);
    run_random_phase(rand_field(), 1'b0);

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
design/me_pkg.sv
design/me_req_if.sv
design/me_rsp_if.sv
design/me_dp.sv
design/me_ctrl.sv
design/modular_exponentiation.sv
tb/power_mod_checker.sv
tb/tb.sv
